@@ rtl/cbvt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbvt_pkg: shared types and constants
// Status codes, register indexes and fixed widths of the camera basis block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbvt_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FOCUS_X = 2'd0;
    localparam logic [1:0] CFG_FOCUS_Y = 2'd1;
    localparam logic [1:0] CFG_FOCUS_Z = 2'd2;

    // Fixed widths of the orthogonalization and normalization paths
    localparam int PRE_LO_TOP = 15;   // prescale target before Gram-Schmidt
    localparam int PRE_HI_TOP = 30;   // prescale target before normalizing
    localparam int FS_W       = 16;   // prescaled forward / up component
    localparam int FF_W       = 32;   // forward dot forward (unsigned)
    localparam int WF_W       = 34;   // up dot forward (signed)
    localparam int R_W        = 49;   // residual up component (signed)
    localparam int SQ_W       = 62;   // sum of squares of a prescaled vector
    localparam int ROOT_W     = 31;   // integer square root of that sum

    // Command to the shared root / divide unit
    typedef struct packed {
        logic start;
        logic sqrt_op;
    } cbvt_rd_cmd_t;

endpackage

`default_nettype wire

@@ rtl/cbvt_rootdiv.sv @@
// ----------------------------------------------------------------------------
// cbvt_rootdiv: iterative square root and divider
// Bit-serial integer square root (two bits a step) and restoring divider
// (one quotient bit a step), sharing one command port and result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbvt_rootdiv
    import cbvt_pkg::*;
#(
    parameter int DW = 47
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbvt_rd_cmd_t        cmd,
    input  wire logic [SQ_W-1:0]     radicand,
    input  wire logic [DW-1:0]       dividend,
    input  wire logic [ROOT_W-1:0]   divisor,
    output logic                     done,
    output logic [DW-1:0]            result
);

    localparam int CNT_W     = $clog2(DW);
    localparam int SQ_STEPS  = SQ_W / 2;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                sqrt_reg, sqrt_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SQ_W-1:0]     s_reg, s_next;
    logic [SQ_W:0]       r_reg, r_next;
    logic [SQ_W:0]       bit_reg, bit_next;
    logic [DW-1:0]       dvd_reg, dvd_next;
    logic [ROOT_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   dvsr_reg, dvsr_next;
    logic [DW-1:0]       quo_reg, quo_next;

    logic [SQ_W:0]       trial;
    logic                sq_ge;
    logic [ROOT_W:0]     rem_sh;
    logic                dv_ge;

    // One step of each recurrence
    always_comb
    begin
        trial  = r_reg + bit_reg;
        sq_ge  = {1'b0, s_reg} >= trial;
        rem_sh = {rem_reg, dvd_reg[DW-1]};
        dv_ge  = rem_sh >= {1'b0, dvsr_reg};
    end

    // Sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        s_next    = s_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next = 1'b1;
                sqrt_next = cmd.sqrt_op;
                if (cmd.sqrt_op)
                begin
                    s_next   = radicand;
                    r_next   = '0;
                    bit_next = (SQ_W+1)'(1) << (SQ_W - 2);
                    cnt_next = CNT_W'(SQ_STEPS - 1);
                end
                else
                begin
                    dvd_next  = dividend;
                    rem_next  = '0;
                    quo_next  = '0;
                    dvsr_next = divisor;
                    cnt_next  = CNT_W'(DW - 1);
                end
            end
        end
        else
        begin
            if (sqrt_reg)
            begin
                if (sq_ge)
                begin
                    s_next = s_reg - trial[SQ_W-1:0];
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                rem_next = dv_ge ? ROOT_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[ROOT_W-1:0];
                quo_next = {quo_reg[DW-2:0], dv_ge};
                dvd_next = dvd_reg << 1;
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sqrt_reg <= sqrt_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign done   = done_reg;
    assign result = sqrt_reg ? DW'(r_reg[ROOT_W-1:0]) : quo_reg;

endmodule

`default_nettype wire

@@ rtl/camera_basis_view_transform.sv @@
// ----------------------------------------------------------------------------
// camera_basis_view_transform: camera basis and view transform
// Keeps a right / up / forward basis, rebuilds it from forward and up
// vectors, and projects points relative to the focus onto it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, fields mode, ax..bz) takes one word
//   at a time; in_stall stays high from acceptance until the result has been
//   placed in the output register. Output channel (out_valid / out_stall,
//   fields rx, ry, rz, status) holds its word until taken; the next input
//   word can be accepted while a result still waits there.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   focus registers; cfg_ready is always high.
// Work:
//   Transform: nine products, each a multiply state and an accumulate
//   state on the one shared multiplier, before the result is offered.
//   Orient: its time is set mostly by the nine bit-serial divisions
//   (FRAC_BITS+31 steps each) and three 31-step square roots in the
//   root/divide unit, plus one-bit-a-cycle prescaling.
// Reset:
//   Basis returns to right (0,0,1), up (0,1,0), forward (1,0,0), focus to 0,
//   no result pending. A stalled receiver holds the finished word in the
//   output register and the sequencer waits before writing a newer one.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_basis_view_transform
    import cbvt_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        mode,
    input  wire logic signed [WORD_BITS-1:0] ax,
    input  wire logic signed [WORD_BITS-1:0] ay,
    input  wire logic signed [WORD_BITS-1:0] az,
    input  wire logic signed [WORD_BITS-1:0] bx,
    input  wire logic signed [WORD_BITS-1:0] by,
    input  wire logic signed [WORD_BITS-1:0] bz,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [WORD_BITS-1:0]      rx,
    output logic signed [WORD_BITS-1:0]      ry,
    output logic signed [WORD_BITS-1:0]      rz,
    output logic [1:0]                       status,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [WORD_BITS-1:0]        cfg_data
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int MA = (W + 1 > 34) ? W + 1 : 34;   // multiplier operand a
    localparam int MB = 32;                          // multiplier operand b
    localparam int PW = MA + MB;
    localparam int AW = PW + 2;
    localparam int VM = (W > 48) ? W : 48;           // prescaler magnitude
    localparam int NW = F + 2;                       // unit vector component
    localparam int CW = F + 3;                       // cross product component
    localparam int DW = F + 31;                      // dividend width

    localparam logic signed [AW-1:0] WMAX_A = AW'({(W-1){1'b1}});
    localparam logic signed [AW-1:0] WMIN_A = -WMAX_A - AW'(1);
    localparam logic signed [AW-1:0] HALF_A = AW'(1) << (F - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRE    = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_ACC    = 4'd3;
    localparam logic [3:0] S_LOADN  = 4'd4;
    localparam logic [3:0] S_ROOT   = 4'd5;
    localparam logic [3:0] S_RWAIT  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DWAIT  = 4'd8;
    localparam logic [3:0] S_COMMIT = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // Program phases
    localparam logic [3:0] PH_F15 = 4'd0;
    localparam logic [3:0] PH_W15 = 4'd1;
    localparam logic [3:0] PH_FF  = 4'd2;
    localparam logic [3:0] PH_WF  = 4'd3;
    localparam logic [3:0] PH_R   = 4'd4;
    localparam logic [3:0] PH_NF  = 4'd5;
    localparam logic [3:0] PH_NR  = 4'd6;
    localparam logic [3:0] PH_C   = 4'd7;
    localparam logic [3:0] PH_NC  = 4'd8;
    localparam logic [3:0] PH_T   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] ph_reg, ph_next;
    logic [3:0] k_reg, k_next;
    logic       sat_reg, sat_next;

    logic signed [W-1:0]    focus_reg [3];
    logic signed [W-1:0]    basis_reg [9];
    logic signed [W-1:0]    basis_next [9];
    logic signed [W-1:0]    a_reg [3], a_next [3];
    logic signed [W-1:0]    b_reg [3], b_next [3];
    logic signed [W:0]      d_reg [3], d_next [3];
    logic [VM-1:0]          nv_reg [3], nv_next [3];
    logic                   neg_reg [3], neg_next [3];
    logic signed [FS_W-1:0] fs_reg [3], fs_next [3];
    logic signed [FS_W-1:0] ws_reg [3], ws_next [3];
    logic [FF_W-1:0]        ff_reg, ff_next;
    logic signed [WF_W-1:0] wf_reg, wf_next;
    logic signed [R_W-1:0]  r_reg [3], r_next [3];
    logic signed [CW-1:0]   c_reg [3], c_next [3];
    logic signed [NW-1:0]   nf_reg [3], nf_next [3];
    logic signed [NW-1:0]   nr_reg [3], nr_next [3];
    logic signed [NW-1:0]   nc_reg [3], nc_next [3];
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic signed [PW-1:0]   p_reg, p_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic signed [W-1:0]    res_reg [3], res_next [3];
    logic [1:0]             st_reg, st_next;
    logic                   ov_reg;
    logic signed [W-1:0]    ox_reg, oy_reg, oz_reg;
    logic [1:0]             os_reg;

    logic signed [MA-1:0]   op_a;
    logic signed [MB-1:0]   op_b;
    logic [1:0]             col;
    logic [1:0]             row;
    logic                   fresh;
    logic                   sub;
    logic signed [AW-1:0]   acc_sum;
    logic signed [AW-1:0]   rnd;
    logic                   hi15, lo15, hi30, lo30, pre_hi, pre_lo, pre_zero;
    logic                   top15;
    logic                   out_free;
    logic signed [NW-1:0]   qv;
    logic [DW-1:0]          dividend;
    cbvt_rd_cmd_t           rd_cmd;
    logic                   rd_done;
    logic [DW-1:0]          rd_result;

    // Magnitude of a sign-extended value
    function automatic logic [VM-1:0] mag_of(input logic signed [VM:0] x);
        logic signed [VM:0] t;
        t = x[VM] ? -x : x;
        return t[VM-1:0];
    endfunction

    // Shift right by FRAC_BITS, rounding half away from zero
    function automatic logic signed [AW-1:0] shr_round(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] m;
        logic signed [AW-1:0] q;
        m = x[AW-1] ? -x : x;
        q = (m + HALF_A) >>> F;
        return x[AW-1] ? -q : q;
    endfunction

    // Shared root / divide unit
    cbvt_rootdiv #(
        .DW (DW)
    ) u_rootdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rd_cmd),
        .radicand (sq_reg),
        .dividend (dividend),
        .divisor  (root_reg),
        .done     (rd_done),
        .result   (rd_result)
    );

    // Prescaler range checks
    always_comb
    begin
        hi15 = 1'b0;
        hi30 = 1'b0;
        lo15 = 1'b1;
        lo30 = 1'b1;
        pre_zero = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            hi15 = hi15 | (|nv_reg[i][VM-1:PRE_LO_TOP]);
            hi30 = hi30 | (|nv_reg[i][VM-1:PRE_HI_TOP]);
            lo15 = lo15 & ~(|nv_reg[i][VM-1:PRE_LO_TOP-1]);
            lo30 = lo30 & ~(|nv_reg[i][VM-1:PRE_HI_TOP-1]);
            pre_zero = pre_zero & (nv_reg[i] == '0);
        end
        top15  = (ph_reg == PH_F15) || (ph_reg == PH_W15);
        pre_hi = top15 ? hi15 : hi30;
        pre_lo = top15 ? lo15 : lo30;
    end

    // Row and column of a transform product
    always_comb
    begin
        case (k_reg)
            4'd0, 4'd3, 4'd6: col = 2'd0;
            4'd1, 4'd4, 4'd7: col = 2'd1;
            default:          col = 2'd2;
        endcase
        if (k_reg < 4'd3)
            row = 2'd0;
        else if (k_reg < 4'd6)
            row = 2'd1;
        else
            row = 2'd2;
    end

    // Shared multiplier operand select
    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        fresh = (k_reg == 4'd0);
        sub   = 1'b0;
        unique case (ph_reg)
            PH_FF:
            begin
                op_a = MA'(fs_reg[k_reg[1:0]]);
                op_b = MB'(fs_reg[k_reg[1:0]]);
            end
            PH_WF:
            begin
                op_a = MA'(ws_reg[k_reg[1:0]]);
                op_b = MB'(fs_reg[k_reg[1:0]]);
            end
            PH_R:
            begin
                fresh = ~k_reg[0];
                sub   = k_reg[0];
                if (k_reg[0])
                begin
                    op_a = MA'(wf_reg);
                    op_b = MB'(fs_reg[k_reg[2:1]]);
                end
                else
                begin
                    op_a = MA'(ff_reg);
                    op_b = MB'(ws_reg[k_reg[2:1]]);
                end
            end
            PH_NF, PH_NR, PH_NC:
            begin
                op_a = MA'(nv_reg[k_reg[1:0]][PRE_HI_TOP-1:0]);
                op_b = MB'(nv_reg[k_reg[1:0]][PRE_HI_TOP-1:0]);
            end
            PH_C:
            begin
                fresh = ~k_reg[0];
                sub   = k_reg[0];
                case (k_reg)
                    4'd0:    begin op_a = MA'(nf_reg[1]); op_b = MB'(nr_reg[2]); end
                    4'd1:    begin op_a = MA'(nf_reg[2]); op_b = MB'(nr_reg[1]); end
                    4'd2:    begin op_a = MA'(nf_reg[2]); op_b = MB'(nr_reg[0]); end
                    4'd3:    begin op_a = MA'(nf_reg[0]); op_b = MB'(nr_reg[2]); end
                    4'd4:    begin op_a = MA'(nf_reg[0]); op_b = MB'(nr_reg[1]); end
                    default: begin op_a = MA'(nf_reg[1]); op_b = MB'(nr_reg[0]); end
                endcase
            end
            PH_T:
            begin
                fresh = (col == 2'd0);
                op_a  = MA'(d_reg[col]);
                op_b  = MB'(basis_reg[k_reg]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Accumulator, rounding, quotient sign and dividend
    always_comb
    begin
        acc_sum  = (fresh ? AW'(0) : acc_reg) + (sub ? -AW'(p_reg) : AW'(p_reg));
        rnd      = shr_round(acc_sum);
        qv       = {1'b0, rd_result[F:0]};
        if (neg_reg[k_reg[1:0]])
            qv = -qv;
        dividend = (DW'(nv_reg[k_reg[1:0]][PRE_HI_TOP-1:0]) << F) + DW'(root_reg >> 1);
    end

    assign out_free = !ov_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        sat_next   = sat_reg;
        basis_next = basis_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        nv_next    = nv_reg;
        neg_next   = neg_reg;
        fs_next    = fs_reg;
        ws_next    = ws_reg;
        ff_next    = ff_reg;
        wf_next    = wf_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        nf_next    = nf_reg;
        nr_next    = nr_reg;
        nc_next    = nc_reg;
        sq_next    = sq_reg;
        root_next  = root_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        rd_cmd     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next[0] = ax;
                    a_next[1] = ay;
                    a_next[2] = az;
                    b_next[0] = bx;
                    b_next[1] = by;
                    b_next[2] = bz;
                    k_next    = '0;
                    sat_next  = 1'b0;
                    if (mode)
                    begin
                        d_next[0]  = (W+1)'(ax) - (W+1)'(focus_reg[0]);
                        d_next[1]  = (W+1)'(ay) - (W+1)'(focus_reg[1]);
                        d_next[2]  = (W+1)'(az) - (W+1)'(focus_reg[2]);
                        ph_next    = PH_T;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        nv_next[0]  = mag_of((VM+1)'(ax));
                        nv_next[1]  = mag_of((VM+1)'(ay));
                        nv_next[2]  = mag_of((VM+1)'(az));
                        neg_next[0] = ax[W-1];
                        neg_next[1] = ay[W-1];
                        neg_next[2] = az[W-1];
                        ph_next     = PH_F15;
                        state_next  = S_PRE;
                    end
                end
            end
            S_PRE:
            begin
                if (pre_zero)
                begin
                    res_next   = basis_reg[0:2];
                    st_next    = ST_DEGEN;
                    state_next = S_DONE;
                end
                else if (pre_hi)
                begin
                    for (int i = 0; i < 3; i++)
                        nv_next[i] = nv_reg[i] >> 1;
                end
                else if (pre_lo)
                begin
                    for (int i = 0; i < 3; i++)
                        nv_next[i] = nv_reg[i] << 1;
                end
                else
                begin
                    k_next = '0;
                    case (ph_reg)
                        PH_F15:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                fs_next[i] = FS_W'({1'b0, nv_reg[i][PRE_LO_TOP-1:0]});
                                if (neg_reg[i])
                                    fs_next[i] = -fs_next[i];
                                nv_next[i]  = mag_of((VM+1)'(b_reg[i]));
                                neg_next[i] = b_reg[i][W-1];
                            end
                            ph_next = PH_W15;
                        end
                        PH_W15:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                ws_next[i] = FS_W'({1'b0, nv_reg[i][PRE_LO_TOP-1:0]});
                                if (neg_reg[i])
                                    ws_next[i] = -ws_next[i];
                            end
                            ph_next    = PH_FF;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                p_next     = op_a * op_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next   = acc_sum;
                state_next = S_MUL;
                k_next     = k_reg + 1'b1;
                case (ph_reg)
                    PH_FF:
                    begin
                        if (k_reg == 4'd2)
                        begin
                            ff_next = acc_sum[FF_W-1:0];
                            ph_next = PH_WF;
                            k_next  = '0;
                        end
                    end
                    PH_WF:
                    begin
                        if (k_reg == 4'd2)
                        begin
                            wf_next = acc_sum[WF_W-1:0];
                            ph_next = PH_R;
                            k_next  = '0;
                        end
                    end
                    PH_R:
                    begin
                        if (k_reg[0])
                            r_next[k_reg[2:1]] = acc_sum[R_W-1:0];
                        if (k_reg == 4'd5)
                        begin
                            ph_next    = PH_NF;
                            state_next = S_LOADN;
                        end
                    end
                    PH_C:
                    begin
                        if (k_reg[0])
                            c_next[k_reg[2:1]] = rnd[CW-1:0];
                        if (k_reg == 4'd5)
                        begin
                            ph_next    = PH_NC;
                            state_next = S_LOADN;
                        end
                    end
                    PH_T:
                    begin
                        if (col == 2'd2)
                        begin
                            if (rnd > WMAX_A)
                            begin
                                res_next[row] = WMAX_A[W-1:0];
                                sat_next      = 1'b1;
                            end
                            else if (rnd < WMIN_A)
                            begin
                                res_next[row] = WMIN_A[W-1:0];
                                sat_next      = 1'b1;
                            end
                            else
                            begin
                                res_next[row] = rnd[W-1:0];
                            end
                        end
                        if (k_reg == 4'd8)
                        begin
                            st_next    = sat_next ? ST_SAT : ST_OK;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        // sum of squares for normalization
                        if (k_reg == 4'd2)
                        begin
                            sq_next    = acc_sum[SQ_W-1:0];
                            state_next = S_ROOT;
                        end
                    end
                endcase
            end
            S_LOADN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    case (ph_reg)
                        PH_NF:
                        begin
                            nv_next[i]  = mag_of((VM+1)'(a_reg[i]));
                            neg_next[i] = a_reg[i][W-1];
                        end
                        PH_NR:
                        begin
                            nv_next[i]  = mag_of((VM+1)'(r_reg[i]));
                            neg_next[i] = r_reg[i][R_W-1];
                        end
                        default:
                        begin
                            nv_next[i]  = mag_of((VM+1)'(c_reg[i]));
                            neg_next[i] = c_reg[i][CW-1];
                        end
                    endcase
                end
                state_next = S_PRE;
            end
            S_ROOT:
            begin
                rd_cmd.start   = 1'b1;
                rd_cmd.sqrt_op = 1'b1;
                state_next     = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (rd_done)
                begin
                    root_next = rd_result[ROOT_W-1:0];
                    k_next    = '0;
                    if (rd_result[ROOT_W-1:0] == '0)
                    begin
                        res_next   = basis_reg[0:2];
                        st_next    = ST_DEGEN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rd_cmd.start   = 1'b1;
                rd_cmd.sqrt_op = 1'b0;
                state_next     = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (rd_done)
                begin
                    case (ph_reg)
                        PH_NF:   nf_next[k_reg[1:0]] = qv;
                        PH_NR:   nr_next[k_reg[1:0]] = qv;
                        default: nc_next[k_reg[1:0]] = qv;
                    endcase
                    if (k_reg == 4'd2)
                    begin
                        k_next = '0;
                        case (ph_reg)
                            PH_NF:
                            begin
                                ph_next    = PH_NR;
                                state_next = S_LOADN;
                            end
                            PH_NR:
                            begin
                                ph_next    = PH_C;
                                state_next = S_MUL;
                            end
                            default:
                            begin
                                state_next = S_COMMIT;
                            end
                        endcase
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_COMMIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    basis_next[i]     = W'(nc_reg[i]);
                    basis_next[3 + i] = W'(nr_reg[i]);
                    basis_next[6 + i] = W'(nf_reg[i]);
                    res_next[i]       = W'(nc_reg[i]);
                end
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_F15;
            k_reg     <= '0;
            sat_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
                focus_reg[i] <= '0;
            // right (0,0,1), up (0,1,0), forward (1,0,0)
            for (int i = 0; i < 9; i++)
                basis_reg[i] <= ((i == 2) || (i == 4) || (i == 6)) ? (W'(1) << F) : W'(0);
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            sat_reg   <= sat_next;
            basis_reg <= basis_next;
            if ((state_reg == S_DONE) && out_free)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FOCUS_X: focus_reg[0] <= cfg_data;
                    CFG_FOCUS_Y: focus_reg[1] <= cfg_data;
                    CFG_FOCUS_Z: focus_reg[2] <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        nv_reg   <= nv_next;
        neg_reg  <= neg_next;
        fs_reg   <= fs_next;
        ws_reg   <= ws_next;
        ff_reg   <= ff_next;
        wf_reg   <= wf_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        nf_reg   <= nf_next;
        nr_reg   <= nr_next;
        nc_reg   <= nc_next;
        sq_reg   <= sq_next;
        root_reg <= root_next;
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            ox_reg <= res_reg[0];
            oy_reg <= res_reg[1];
            oz_reg <= res_reg[2];
            os_reg <= st_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign rx        = ox_reg;
    assign ry        = oy_reg;
    assign rz        = oz_reg;
    assign status    = os_reg;

endmodule

`default_nettype wire

@@ rtl/cbvt_checker.sv @@
// ----------------------------------------------------------------------------
// cbvt_checker: port-level checks
// Watches the camera basis block's channels and flags protocol or sequencing
// slips; attached to the top level by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cbvt_checker
    import cbvt_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic signed [WORD_BITS-1:0] rx,
    input wire logic signed [WORD_BITS-1:0] ry,
    input wire logic signed [WORD_BITS-1:0] rz,
    input wire logic [1:0]                  status
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({rx, ry, rz, status}))
        else $error("result word changed while stalled");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_DEGEN) || (status == ST_SAT))
        else $error("undefined status code");

    // An accepted word keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input reopened right after acceptance");

    // A new result only appears out of a busy sequencer
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word appeared without work in flight");

endmodule

bind camera_basis_view_transform cbvt_checker #(
    .WORD_BITS (WORD_BITS)
) u_cbvt_checker (.*);

`default_nettype wire

@@ sim/camera_basis_view_transform_checker.sv @@
// ----------------------------------------------------------------------------
// camera_basis_view_transform_checker: basis and projection scoreboard
// Watches the input, output and config channels, keeps its own copy of the
// camera basis and focus, predicts each result word and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_basis_view_transform_checker
    import cbvt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        mode,
    input  wire logic [31:0] ax,
    input  wire logic [31:0] ay,
    input  wire logic [31:0] az,
    input  wire logic [31:0] bx,
    input  wire logic [31:0] by,
    input  wire logic [31:0] bz,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] rx,
    input  wire logic [31:0] ry,
    input  wire logic [31:0] rz,
    input  wire logic [1:0]  status,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               words_pending
);

    localparam int  FRAC = 16;
    localparam longint ONE_Q  = 64'sd1 <<< FRAC;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef logic [2:0][63:0] vec3_t;

    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [1:0]  status;
    } view_word_t;

    longint     basis [9];
    longint     focus [3];
    view_word_t view_q [$];

    function automatic longint unsigned magn(longint x);
        return (x < 0) ? longint'(0) - x : x;
    endfunction

    function automatic longint signed_of(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_frac(longint x);
        return signed_of((magn(x) + (64'd1 << (FRAC - 1))) >> FRAC, x < 0);
    endfunction

    // shift so the largest magnitude has exactly top bits
    function automatic vec3_t scale_to(vec3_t v, int top);
        longint unsigned m;
        longint unsigned a;
        int len;
        vec3_t o;
        m = 0;
        len = 0;
        for (int i = 0; i < 3; i++)
            if (magn(v[i]) > m) m = magn(v[i]);
        while (len < 64 && (m >> len) != 0) len++;
        for (int i = 0; i < 3; i++)
        begin
            a = magn(v[i]);
            a = (len > top) ? a >> (len - top) : a << (top - len);
            o[i] = signed_of(a, $signed(v[i]) < 0);
        end
        return o;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q16; caller guarantees a nonzero input
    function automatic vec3_t unit_of(vec3_t v, output bit ok);
        vec3_t s;
        vec3_t o;
        longint unsigned sum;
        longint unsigned root;
        s = scale_to(v, 30);
        sum = 0;
        for (int i = 0; i < 3; i++) sum += magn(s[i]) * magn(s[i]);
        root = int_sqrt(sum);
        ok = (root != 0);
        o = '0;
        if (ok)
            for (int i = 0; i < 3; i++)
                o[i] = signed_of(((magn(s[i]) << FRAC) + root / 2) / root,
                                 $signed(s[i]) < 0);
        return o;
    endfunction

    // rebuild the basis from forward f and up w; returns status
    function automatic logic [1:0] reorient(vec3_t f, vec3_t w, output vec3_t right);
        vec3_t fs, ws, res, nf, nr, c, nc;
        longint ff, wf;
        bit ok1, ok2, ok3;
        for (int i = 0; i < 3; i++) right[i] = basis[i];
        if (f == '0 || w == '0) return ST_DEGEN;
        fs = scale_to(f, 15);
        ws = scale_to(w, 15);
        ff = 0;
        wf = 0;
        for (int i = 0; i < 3; i++)
        begin
            ff += $signed(fs[i]) * $signed(fs[i]);
            wf += $signed(ws[i]) * $signed(fs[i]);
        end
        for (int i = 0; i < 3; i++)
            res[i] = ff * $signed(ws[i]) - wf * $signed(fs[i]);
        if (res == '0) return ST_DEGEN;
        nf = unit_of(f, ok1);
        nr = unit_of(res, ok2);
        if (!ok1 || !ok2) return ST_DEGEN;
        c[0] = round_frac($signed(nf[1]) * $signed(nr[2]) - $signed(nf[2]) * $signed(nr[1]));
        c[1] = round_frac($signed(nf[2]) * $signed(nr[0]) - $signed(nf[0]) * $signed(nr[2]));
        c[2] = round_frac($signed(nf[0]) * $signed(nr[1]) - $signed(nf[1]) * $signed(nr[0]));
        if (c == '0) return ST_DEGEN;
        nc = unit_of(c, ok3);
        if (!ok3) return ST_DEGEN;
        for (int i = 0; i < 3; i++)
        begin
            basis[i]     = nc[i];
            basis[3 + i] = nr[i];
            basis[6 + i] = nf[i];
            right[i]     = nc[i];
        end
        return ST_OK;
    endfunction

    function automatic view_word_t predict_view(logic m, vec3_t a, vec3_t b);
        view_word_t w;
        vec3_t out;
        longint d [3];
        longint acc;
        longint v;
        w.status = ST_OK;
        if (!m)
            w.status = reorient(a, b, out);
        else
        begin
            for (int i = 0; i < 3; i++) d[i] = $signed(a[i]) - focus[i];
            for (int k = 0; k < 3; k++)
            begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += basis[3 * k + i] * d[i];
                v = round_frac(acc);
                if (v > WORD_MAX)
                begin
                    v = WORD_MAX;
                    w.status = ST_SAT;
                end
                else if (v < WORD_MIN)
                begin
                    v = WORD_MIN;
                    w.status = ST_SAT;
                end
                out[k] = v;
            end
        end
        w.rx = out[0][31:0];
        w.ry = out[1][31:0];
        w.rz = out[2][31:0];
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // follow the channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++) basis[i] = 0;
            basis[2] = ONE_Q;
            basis[4] = ONE_Q;
            basis[6] = ONE_Q;
            for (int i = 0; i < 3; i++) focus[i] = 0;
            view_q.delete();
            fail_count = 0;
        end
        else
        begin
            view_word_t got;
            view_word_t exp_w;
            vec3_t av, bv;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FOCUS_X: focus[0] = longint'($signed(cfg_data));
                    CFG_FOCUS_Y: focus[1] = longint'($signed(cfg_data));
                    CFG_FOCUS_Z: focus[2] = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got.rx = rx;
                got.ry = ry;
                got.rz = rz;
                got.status = status;
                if (view_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %h %h %h %h",
                             $time, rx, ry, rz, status);
                    fail_count++;
                end
                else
                begin
                    exp_w = view_q.pop_front();
                    check_field("rx", exp_w.rx, got.rx);
                    check_field("ry", exp_w.ry, got.ry);
                    check_field("rz", exp_w.rz, got.rz);
                    check_field("status", 32'(exp_w.status), 32'(got.status));
                end
            end
            if (in_valid && !in_stall)
            begin
                av[0] = 64'($signed(ax));
                av[1] = 64'($signed(ay));
                av[2] = 64'($signed(az));
                bv[0] = 64'($signed(bx));
                bv[1] = 64'($signed(by));
                bv[2] = 64'($signed(bz));
                view_q.push_back(predict_view(mode, av, bv));
            end
        end
        words_pending = view_q.size();
    end

endmodule

`default_nettype wire

@@ sim/camera_basis_view_transform_test.sv @@
// ----------------------------------------------------------------------------
// camera_basis_view_transform_test: top-level testbench
// Drives orient and transform words with random gaps and output stalls,
// moves the focus through several settings, and reports the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_basis_view_transform_test;
    import cbvt_pkg::*;

    localparam logic MODE_ORIENT    = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;
    localparam logic [31:0] W_MAX = 32'h7fffffff;
    localparam logic [31:0] W_MIN = 32'h80000000;
    localparam logic [31:0] Q_ONE = 32'h00010000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [31:0] ax, ay, az, bx, by, bz;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] rx, ry, rz;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          words_pending;
    bit          stall_quiet;

    camera_basis_view_transform u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .out_valid(out_valid), .out_stall(out_stall),
        .rx(rx), .ry(ry), .rz(rz), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    camera_basis_view_transform_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .out_valid(out_valid), .out_stall(out_stall),
        .rx(rx), .ry(ry), .rz(rz), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // component with a spread of magnitudes, zero and extremes
    function automatic logic [31:0] rand_comp();
        logic [31:0] m;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:
            begin
                m = $urandom >> $urandom_range(0, 31);
                return $urandom_range(0, 1) ? -m : m;
            end
            3: return 32'd0;
            4: return $urandom_range(0, 1) ? W_MAX : W_MIN;
            default:
            begin
                m = $urandom_range(0, 4) * Q_ONE;
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    task automatic send_word(logic m, logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                             logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        ax <= x0; ay <= y0; az <= z0;
        bx <= x1; by <= y1; bz <= z1;
        do @(posedge clk); while (in_stall);
    endtask

    // hold off until every word has come back, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_focus(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz);
        logic [31:0] vals [3];
        vals = '{fx, fy, fz};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_FOCUS_X : (i == 1) ? CFG_FOCUS_Y : CFG_FOCUS_Z;
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word();
        logic [31:0] f [3];
        logic [31:0] u [3];
        int k;
        if ($urandom_range(0, 99) < 85)
            send_word(MODE_TRANSFORM, rand_comp(), rand_comp(), rand_comp(),
                      $urandom, $urandom, $urandom);
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                f[i] = rand_comp();
                u[i] = rand_comp();
            end
            k = $urandom_range(0, 9);
            // parallel or opposite up vector
            if (k == 0) u = f;
            if (k == 1) for (int i = 0; i < 3; i++) u[i] = -f[i];
            send_word(MODE_ORIENT, f[0], f[1], f[2], u[0], u[1], u[2]);
        end
    endtask

    // output stall: stretches of occasional short stalls and quiet stretches with none
    initial
    begin
        out_stall = 1'b0;
        stall_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0) stall_quiet = ~stall_quiet;
            if (stall_quiet)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 3)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 9) < 6)
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_TRANSFORM;
        {ax, ay, az, bx, by, bz} = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FOCUS_X;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, starting from the reset basis and focus
        send_word(MODE_TRANSFORM, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 0, 0, 0);
        send_word(MODE_TRANSFORM, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX);
        send_word(MODE_TRANSFORM, W_MIN, W_MIN, W_MIN, 0, 0, 0);
        send_word(MODE_ORIENT, 0, 0, 0, 0, Q_ONE, 0);
        send_word(MODE_ORIENT, Q_ONE, 0, 0, 0, 0, 0);
        send_word(MODE_ORIENT, Q_ONE, Q_ONE, 0, 2 * Q_ONE, 2 * Q_ONE, 0);
        send_word(MODE_ORIENT, W_MIN, 0, 0, W_MAX, 0, 0);
        send_word(MODE_ORIENT, Q_ONE, 0, 0, 0, Q_ONE, 0);
        send_word(MODE_TRANSFORM, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 0, 0, 0);
        send_word(MODE_ORIENT, 0, 0, Q_ONE, 0, Q_ONE, 0);
        send_word(MODE_ORIENT, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MAX);
        send_word(MODE_TRANSFORM, W_MAX, W_MAX, W_MIN, 0, 0, 0);
        send_word(MODE_ORIENT, 1, 0, 0, 0, 1, 0);
        send_word(MODE_ORIENT, 32'hffffffff, 1, 0, 0, 0, 32'hffffffff);
        send_word(MODE_TRANSFORM, 32'h12345678, 32'hedcba987, 32'h00008000, W_MAX, W_MAX, W_MAX);
        send_word(MODE_ORIENT, 3 * Q_ONE, -4 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        send_word(MODE_TRANSFORM, 0, 0, 0, 0, 0, 0);
        drain();

        // focus settings, extremes among them, each with a random run
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_focus(0, 0, 0);
                1: write_focus(W_MAX, W_MIN, W_MAX);
                2: write_focus($urandom, $urandom, $urandom);
                3: write_focus(W_MIN, W_MAX, W_MIN);
                4: write_focus(rand_comp(), rand_comp(), rand_comp());
                default: write_focus(Q_ONE, -Q_ONE, 32'h00008000);
            endcase
            for (int n = 0; n < 250; n++) random_word();
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
